>>> rtl/min_tracking_fifo_queue_assert.svh
// Assertion macros shared by the checker of min_tracking_fifo_queue.
// Depends on nothing; take it in by `include after the timescale line.
`ifndef MIN_TRACKING_FIFO_QUEUE_ASSERT_SVH
`define MIN_TRACKING_FIFO_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MTFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtfq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MTFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtfq assertion failed");

`endif

>>> rtl/mtfq_pkg.sv
// Package for the min-tracking FIFO queue: sizes, codes, transaction structs,
// controller commands and status. Depends on nothing.
`timescale 1ns / 1ps

package mtfq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic signed [VAL_W-1:0] back_value;
        logic signed [VAL_W-1:0] current_min;
        logic [OCC_W-1:0]        occupancy;
        logic                    queue_empty;
        logic [1:0]              error_code;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFER,
        ST_POP,
        ST_REFILL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic       start;
        logic       push;
        logic       xfer;
        logic       xfer_first;
        logic       pop;
        logic       refill;
        logic       load;
        logic [1:0] err;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic out_zero;
        logic in_last;
        logic full;
    } stat_t;

    function automatic logic signed [VAL_W-1:0] smin(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

>>> rtl/mtfq_datapath.sv
// Datapath of the min-tracking queue: two stack memories, counts, cached
// stack tops and bottoms, and the result register. Depends on mtfq_pkg.
`timescale 1ns / 1ps

module mtfq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic signed [mtfq_pkg::VAL_W-1:0] push_value,
    input  mtfq_pkg::cmd_t                  cmd,
    output mtfq_pkg::stat_t                 stat,
    output mtfq_pkg::rsp_t                  rsp
);

    logic [mtfq_pkg::CNT_W-1:0] in_cnt_reg, in_cnt_next;
    logic [mtfq_pkg::CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [mtfq_pkg::CNT_W-1:0] total;
    logic [mtfq_pkg::CNT_W-1:0] in_rd_cnt;
    logic [mtfq_pkg::CNT_W-1:0] out_rd_cnt;
    logic                       popped_reg, popped_next;

    logic signed [mtfq_pkg::VAL_W-1:0] in_mem [mtfq_pkg::CAPACITY];
    logic [2*mtfq_pkg::VAL_W-1:0]      out_mem [mtfq_pkg::CAPACITY];
    logic signed [mtfq_pkg::VAL_W-1:0] in_rdata_reg;
    logic [2*mtfq_pkg::VAL_W-1:0]      out_rdata_reg;

    logic signed [mtfq_pkg::VAL_W-1:0] in_top_val_reg, in_top_min_reg, in_bot_reg;
    logic signed [mtfq_pkg::VAL_W-1:0] out_top_val_reg, out_top_min_reg, out_bot_reg;
    logic signed [mtfq_pkg::VAL_W-1:0] popped_val_reg;

    logic signed [mtfq_pkg::VAL_W-1:0] push_min;
    logic signed [mtfq_pkg::VAL_W-1:0] xfer_val;
    logic signed [mtfq_pkg::VAL_W-1:0] xfer_min;

    mtfq_pkg::rsp_t rsp_reg, rsp_next;

    assign total      = in_cnt_reg + out_cnt_reg;
    assign in_rd_cnt  = in_cnt_reg - mtfq_pkg::CNT_W'(2);
    assign out_rd_cnt = out_cnt_reg - mtfq_pkg::CNT_W'(2);

    assign stat.in_zero  = (in_cnt_reg == '0);
    assign stat.out_zero = (out_cnt_reg == '0);
    assign stat.in_last  = (in_cnt_reg == mtfq_pkg::CNT_W'(1));
    assign stat.full     = (total >= mtfq_pkg::CNT_W'(mtfq_pkg::CAPACITY));

    assign push_min = stat.in_zero ? push_value : mtfq_pkg::smin(push_value, in_top_min_reg);
    assign xfer_val = cmd.xfer_first ? in_top_val_reg : in_rdata_reg;
    assign xfer_min = stat.out_zero ? xfer_val : mtfq_pkg::smin(xfer_val, out_top_min_reg);

    always_comb
    begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        popped_next  = popped_reg;
        if (cmd.start)
        begin
            popped_next = 1'b0;
        end
        if (cmd.push)
        begin
            in_cnt_next = in_cnt_reg + mtfq_pkg::CNT_W'(1);
        end
        if (cmd.xfer)
        begin
            in_cnt_next  = in_cnt_reg - mtfq_pkg::CNT_W'(1);
            out_cnt_next = out_cnt_reg + mtfq_pkg::CNT_W'(1);
        end
        if (cmd.pop)
        begin
            out_cnt_next = out_cnt_reg - mtfq_pkg::CNT_W'(1);
            popped_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            popped_reg  <= 1'b0;
        end
        else
        begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            popped_reg  <= popped_next;
        end
    end

    // stack memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            in_mem[in_cnt_reg[mtfq_pkg::IDX_W-1:0]] <= push_value;
        end
        if (cmd.xfer)
        begin
            out_mem[out_cnt_reg[mtfq_pkg::IDX_W-1:0]] <= {xfer_min, xfer_val};
        end
        in_rdata_reg  <= in_mem[in_rd_cnt[mtfq_pkg::IDX_W-1:0]];
        out_rdata_reg <= out_mem[out_rd_cnt[mtfq_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            in_top_val_reg <= push_value;
            in_top_min_reg <= push_min;
            if (stat.in_zero)
            begin
                in_bot_reg <= push_value;
            end
        end
        if (cmd.xfer)
        begin
            out_top_val_reg <= xfer_val;
            out_top_min_reg <= xfer_min;
            if (stat.out_zero)
            begin
                out_bot_reg <= xfer_val;
            end
        end
        if (cmd.pop)
        begin
            popped_val_reg <= out_top_val_reg;
        end
        if (cmd.refill)
        begin
            out_top_val_reg <= out_rdata_reg[mtfq_pkg::VAL_W-1:0];
            out_top_min_reg <= out_rdata_reg[2*mtfq_pkg::VAL_W-1:mtfq_pkg::VAL_W];
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.occupancy   = mtfq_pkg::OCC_W'(total);
        rsp_next.queue_empty = (total == '0);
        rsp_next.error_code  = cmd.err;
        if (popped_reg)
        begin
            rsp_next.out_value = popped_val_reg;
        end
        else if (!stat.out_zero)
        begin
            rsp_next.out_value = out_top_val_reg;
        end
        else if (!stat.in_zero)
        begin
            rsp_next.out_value = in_bot_reg;
        end
        if (!stat.in_zero)
        begin
            rsp_next.back_value = in_top_val_reg;
        end
        else if (!stat.out_zero)
        begin
            rsp_next.back_value = out_bot_reg;
        end
        if (!stat.in_zero && !stat.out_zero)
        begin
            rsp_next.current_min = mtfq_pkg::smin(in_top_min_reg, out_top_min_reg);
        end
        else if (!stat.in_zero)
        begin
            rsp_next.current_min = in_top_min_reg;
        end
        else if (!stat.out_zero)
        begin
            rsp_next.current_min = out_top_min_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/mtfq_ctrl.sv
// Controller of the min-tracking queue: request sequencing, stack transfer
// stepping and output handshake. Depends on mtfq_pkg.
`timescale 1ns / 1ps

module mtfq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      req_type,
    output logic            out_valid,
    input  logic            out_ready,
    input  mtfq_pkg::stat_t stat,
    output mtfq_pkg::cmd_t  cmd
);

    mtfq_pkg::state_t state_reg, state_next;
    logic             pop_pend_reg, pop_pend_next;
    logic             xfer_first_reg, xfer_first_next;
    logic [1:0]       err_reg, err_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtfq_pkg::ST_IDLE;
            pop_pend_reg   <= 1'b0;
            xfer_first_reg <= 1'b0;
            err_reg        <= mtfq_pkg::ERR_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pop_pend_reg   <= pop_pend_next;
            xfer_first_reg <= xfer_first_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pop_pend_next   = pop_pend_reg;
        xfer_first_next = xfer_first_reg;
        err_next        = err_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.err         = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            mtfq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    err_next   = mtfq_pkg::ERR_OK;
                    state_next = mtfq_pkg::ST_RESP;
                    if (req_type == mtfq_pkg::REQ_PUSH)
                    begin
                        if (stat.full)
                        begin
                            err_next = mtfq_pkg::ERR_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (stat.in_zero && stat.out_zero)
                    begin
                        err_next = mtfq_pkg::ERR_EMPTY;
                    end
                    else if (stat.out_zero)
                    begin
                        pop_pend_next   = (req_type == mtfq_pkg::REQ_POP);
                        xfer_first_next = 1'b1;
                        state_next      = mtfq_pkg::ST_XFER;
                    end
                    else if (req_type == mtfq_pkg::REQ_POP)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = mtfq_pkg::ST_REFILL;
                    end
                end
            end
            mtfq_pkg::ST_XFER:
            begin
                cmd.xfer        = 1'b1;
                cmd.xfer_first  = xfer_first_reg;
                xfer_first_next = 1'b0;
                if (stat.in_last)
                begin
                    state_next = pop_pend_reg ? mtfq_pkg::ST_POP : mtfq_pkg::ST_RESP;
                end
            end
            mtfq_pkg::ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = mtfq_pkg::ST_REFILL;
            end
            mtfq_pkg::ST_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = mtfq_pkg::ST_RESP;
            end
            mtfq_pkg::ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mtfq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtfq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/min_tracking_fifo_queue.sv
// Top level of the min-tracking FIFO queue built from two stacks.
// Depends on mtfq_pkg, mtfq_ctrl and mtfq_datapath.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data   (mtfq_pkg::req_t)
//   out     | output    | out_valid / out_ready | out_data  (mtfq_pkg::rsp_t)
//
// Push and peek: the accept moves to the response state, which loads the output register,
// raises out_valid and returns to idle; a pop on a filled out stack passes the refill state first.
// A pop or peek on an empty out stack first moves the in stack across, one entry a cycle
// through each stack memory's single registered read port, and a pop then passes the pop
// and refill states. Reset clears only the counts and control.
// A waiting result holds in the output register; the next transaction is taken and held.
`timescale 1ns / 1ps

module min_tracking_fifo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtfq_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mtfq_pkg::rsp_t out_data
);

    mtfq_pkg::cmd_t  cmd;
    mtfq_pkg::stat_t stat;

    mtfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (in_data.req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtfq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (in_data.push_value),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (out_data)
    );

endmodule

>>> rtl/mtfq_checker.sv
// Port-level checker for min_tracking_fifo_queue, bound to the top level.
// Depends on mtfq_pkg and min_tracking_fifo_queue_assert.svh.
`timescale 1ns / 1ps
`include "min_tracking_fifo_queue_assert.svh"

module mtfq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input mtfq_pkg::rsp_t out_data
);

    logic in_fire;
    logic out_wait;
    logic occ_zero;
    logic full_err;
    logic empty_err;
    logic status_zero;

    assign in_fire     = in_valid && in_ready;
    assign out_wait    = out_valid && !out_ready;
    assign occ_zero    = (out_data.occupancy == '0);
    assign full_err    = out_valid && (out_data.error_code == mtfq_pkg::ERR_FULL);
    assign empty_err   = out_valid && (out_data.error_code == mtfq_pkg::ERR_EMPTY);
    assign status_zero = out_data.queue_empty && (out_data.out_value == '0)
                         && (out_data.current_min == '0);

    `MTFQ_ASSERT_NEXT(a_in_gap, clk, rst_n, in_fire, !in_ready)
    `MTFQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))
    `MTFQ_ASSERT_NOW(a_empty_flag, clk, rst_n, out_valid, out_data.queue_empty == occ_zero)
    `MTFQ_ASSERT_NOW(a_full_err, clk, rst_n, full_err, out_data.occupancy == mtfq_pkg::OCC_FULL)
    `MTFQ_ASSERT_NOW(a_empty_err, clk, rst_n, empty_err, status_zero)

endmodule

bind min_tracking_fifo_queue mtfq_checker u_checker (.*);

>>> dv/min_tracking_fifo_queue_tb.sv
// Self-checking testbench for min_tracking_fifo_queue: directed table, then random bursts of
// push/pop/peek/spare requests, each response checked against its table row or a two-stack
// queue tracker kept in the bench. Depends on mtfq_pkg and the min_tracking_fifo_queue RTL.
`timescale 1ns / 1ps

module min_tracking_fifo_queue_tb;

    localparam logic [1:0] REQ_PEEK  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic signed [mtfq_pkg::VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [mtfq_pkg::VAL_W-1:0] VMIN = 32'sh8000_0000;

    localparam mtfq_pkg::rsp_t RSP_EMPTY =
        '{32'sd0, 32'sd0, 32'sd0, 5'd0, 1'b1, mtfq_pkg::ERR_EMPTY};

    localparam int DIR_N  = 25;
    localparam int RAND_N = 1750;

    typedef struct {
        mtfq_pkg::req_t req;
        bit             typed;
        mtfq_pkg::rsp_t status;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mtfq_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mtfq_pkg::rsp_t out_data;

    bit calm = 1'b0;
    int mismatches = 0;
    mtfq_pkg::rsp_t pending_status[$];
    mtfq_pkg::rsp_t want;

    logic signed [mtfq_pkg::VAL_W-1:0] in_val  [mtfq_pkg::CAPACITY];
    logic signed [mtfq_pkg::VAL_W-1:0] in_min  [mtfq_pkg::CAPACITY];
    logic signed [mtfq_pkg::VAL_W-1:0] out_val [mtfq_pkg::CAPACITY];
    logic signed [mtfq_pkg::VAL_W-1:0] out_min [mtfq_pkg::CAPACITY];
    int in_cnt  = 0;
    int out_cnt = 0;

    dir_row_t dir_tbl [DIR_N] = '{
        '{'{mtfq_pkg::REQ_POP, 32'sd0}, 1'b1, RSP_EMPTY},
        '{'{REQ_PEEK,  32'sd9}, 1'b1, RSP_EMPTY},
        '{'{REQ_SPARE, 32'sd9}, 1'b1, RSP_EMPTY},
        '{'{mtfq_pkg::REQ_PUSH, VMAX}, 1'b1,
          '{VMAX, VMAX, VMAX, 5'd1, 1'b0, mtfq_pkg::ERR_OK}},
        '{'{mtfq_pkg::REQ_PUSH, VMIN}, 1'b1,
          '{VMAX, VMIN, VMIN, 5'd2, 1'b0, mtfq_pkg::ERR_OK}},
        '{'{REQ_PEEK, 32'sd0}, 1'b0, '0},
        '{'{mtfq_pkg::REQ_POP, 32'sd0}, 1'b0, '0},
        '{'{mtfq_pkg::REQ_POP, 32'sd0}, 1'b1,
          '{VMIN, 32'sd0, 32'sd0, 5'd0, 1'b1, mtfq_pkg::ERR_OK}},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd3},    1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, -32'sd3},   1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd100},  1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, -32'sd100}, 1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd0},    1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, -32'sd1},   1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd1},    1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, VMIN},      1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd7},    1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, VMAX},      1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, -32'sd50},  1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd42},   1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, -32'sd7},   1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd2},    1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, VMIN + 1},  1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, VMAX - 1},  1'b0, '0},
        '{'{mtfq_pkg::REQ_PUSH, 32'sd5},    1'b0, '0}
    };

    min_tracking_fifo_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    function automatic mtfq_pkg::rsp_t track_request(input mtfq_pkg::req_t r);
        mtfq_pkg::rsp_t rsp;
        logic signed [mtfq_pkg::VAL_W-1:0] v;
        logic signed [mtfq_pkg::VAL_W-1:0] m;
        bit popped;
        int total;
        rsp = '0;
        popped = 1'b0;
        total = in_cnt + out_cnt;
        if (r.req_type == mtfq_pkg::REQ_PUSH)
        begin
            if (total >= mtfq_pkg::CAPACITY)
            begin
                rsp.error_code = mtfq_pkg::ERR_FULL;
            end
            else
            begin
                m = r.push_value;
                if (in_cnt > 0 && in_min[in_cnt-1] < m)
                    m = in_min[in_cnt-1];
                in_val[in_cnt] = r.push_value;
                in_min[in_cnt] = m;
                in_cnt++;
            end
        end
        else if (total == 0)
        begin
            rsp.error_code = mtfq_pkg::ERR_EMPTY;
        end
        else
        begin
            if (out_cnt == 0)
            begin
                while (in_cnt > 0)
                begin
                    in_cnt--;
                    v = in_val[in_cnt];
                    m = v;
                    if (out_cnt > 0 && out_min[out_cnt-1] < m)
                        m = out_min[out_cnt-1];
                    out_val[out_cnt] = v;
                    out_min[out_cnt] = m;
                    out_cnt++;
                end
            end
            if (r.req_type == mtfq_pkg::REQ_POP)
            begin
                out_cnt--;
                popped = 1'b1;
                rsp.out_value = out_val[out_cnt];
            end
        end
        total = in_cnt + out_cnt;
        if (!popped)
        begin
            if (out_cnt > 0)
                rsp.out_value = out_val[out_cnt-1];
            else if (in_cnt > 0)
                rsp.out_value = in_val[0];
        end
        if (in_cnt > 0)
            rsp.back_value = in_val[in_cnt-1];
        else if (out_cnt > 0)
            rsp.back_value = out_val[0];
        if (in_cnt > 0 && out_cnt > 0)
            rsp.current_min = (in_min[in_cnt-1] < out_min[out_cnt-1]) ?
                              in_min[in_cnt-1] : out_min[out_cnt-1];
        else if (in_cnt > 0)
            rsp.current_min = in_min[in_cnt-1];
        else if (out_cnt > 0)
            rsp.current_min = out_min[out_cnt-1];
        rsp.occupancy = mtfq_pkg::OCC_W'(total);
        rsp.queue_empty = (total == 0);
        return rsp;
    endfunction

    function automatic logic signed [mtfq_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return VMAX;
            1: return VMIN;
            2: return $signed(32'($urandom_range(20))) - 32'sd10;
            3: return ($urandom_range(1) != 0) ? -32'sd1 : 32'sd0;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [1:0] pick_request(input int push_pct);
        int roll;
        if ($urandom_range(99) < push_pct)
            return mtfq_pkg::REQ_PUSH;
        roll = $urandom_range(99);
        if (roll < 65)
            return mtfq_pkg::REQ_POP;
        if (roll < 92)
            return REQ_PEEK;
        return REQ_SPARE;
    endfunction

    task automatic send_request(input mtfq_pkg::req_t r, input bit typed,
                                input mtfq_pkg::rsp_t status);
        mtfq_pkg::rsp_t predicted;
        if (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 13);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
        predicted = track_request(r);
        pending_status.push_back(typed ? status : predicted);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("response transaction with no request pending");
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("out_value", want.out_value, out_data.out_value);
                check_field("back_value", want.back_value, out_data.back_value);
                check_field("current_min", want.current_min, out_data.current_min);
                check_field("occupancy", want.occupancy, out_data.occupancy);
                check_field("queue_empty", want.queue_empty, out_data.queue_empty);
                check_field("error_code", want.error_code, out_data.error_code);
            end
        end
    end

    initial
    begin
        mtfq_pkg::req_t r;
        int push_pct;
        int burst_left;
        burst_left = 0;
        push_pct = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tbl[i])
            send_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].status);
        for (int n = 0; n < RAND_N; n++)
        begin
            calm = (n >= 700 && n < 1000);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(10, 40);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            r.req_type   = pick_request(push_pct);
            r.push_value = pick_value();
            send_request(r, 1'b0, '0);
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS min_tracking_fifo_queue");
        else
            $display("FAIL min_tracking_fifo_queue");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL min_tracking_fifo_queue");
        $finish;
    end

endmodule

>>> min_tracking_fifo_queue.f
+incdir+rtl
rtl/mtfq_pkg.sv
rtl/mtfq_datapath.sv
rtl/mtfq_ctrl.sv
rtl/min_tracking_fifo_queue.sv
rtl/mtfq_checker.sv
dv/min_tracking_fifo_queue_tb.sv
